// ===== design/rkc_pkg.sv =====
// Package for the register/keepalive client: event, packet, phase and status codes.
// Used by the top level and by the port checker; depends on nothing.
package rkc_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PACKET = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_QUIT   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_DISC  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_REGD  = 2'd2,
    PH_ALIVE = 2'd3
  } phase_t;

  localparam logic [7:0] TYPE_REG_REQ    = 8'h00;
  localparam logic [7:0] TYPE_REG_ACK    = 8'h01;
  localparam logic [7:0] TYPE_REG_NACK   = 8'h02;
  localparam logic [7:0] TYPE_REG_REJ    = 8'h03;
  localparam logic [7:0] TYPE_ALIVE_INF  = 8'h10;
  localparam logic [7:0] TYPE_ALIVE_ACK  = 8'h11;
  localparam logic [7:0] TYPE_ALIVE_NACK = 8'h12;
  localparam logic [7:0] TYPE_ALIVE_REJ  = 8'h13;

  localparam logic [1:0] SEND_NONE  = 2'd0;
  localparam logic [1:0] SEND_REQ   = 2'd1;
  localparam logic [1:0] SEND_ALIVE = 2'd2;

  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_REGISTERED = 3'd1;
  localparam logic [2:0] ST_REJECTED   = 3'd2;
  localparam logic [2:0] ST_GAVE_UP    = 3'd3;
  localparam logic [2:0] ST_ALIVE_LOST = 3'd4;
  localparam logic [2:0] ST_ALIVE_REJ  = 3'd5;
  localparam logic [2:0] ST_STOPPED    = 3'd6;

  localparam logic [2:0] CFG_BASE_WAIT     = 3'd0;
  localparam logic [2:0] CFG_WAIT_CAP      = 3'd1;
  localparam logic [2:0] CFG_SENDS_PER_TRY = 3'd2;
  localparam logic [2:0] CFG_TRY_LIMIT     = 3'd3;
  localparam logic [2:0] CFG_PAUSE         = 3'd4;
  localparam logic [2:0] CFG_ALIVE_PERIOD  = 3'd5;
  localparam logic [2:0] CFG_LOST_LIMIT    = 3'd6;

  localparam logic [55:0] RANDOM_RESET = 56'h30303030303000;

endpackage

// ===== design/register_keepalive_client_top.sv =====
// Top level of the register/keepalive client: input register, event logic, result register.
// Depends on rkc_pkg.
//
// Usage: each input item is one event (start, received packet, wait expired, quit) with
// the fields of the packet. For every item exactly one result item comes out: the packet
// to send, its random bytes, the seconds to arm the timer with, the link phase after the
// event and a status code.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while idle; the block does not enforce it. Index 7 is ignored.
// An item accepted when in_valid is high and in_stall is low is loaded into the input
// register; its result is computed from there and is loaded into the result register as
// soon as that register can take it. Throughput: one item per cycle while out_stall is low.
// The event logic reads and updates the client state combinationally between the registers.
// When out_stall is high the result register holds; one more item waits in the input
// register, and only then does in_stall rise.
// Reset (rst, synchronous) empties both registers, loads the configuration defaults and
// puts the client in the disconnected phase.
module register_keepalive_client_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  pkt_type,
  input  logic [55:0] pkt_name,
  input  logic [63:0] pkt_mac_high,
  input  logic [39:0] pkt_mac_low,
  input  logic [55:0] pkt_random,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  send_kind,
  output logic [55:0] random_to_send,
  output logic [6:0]  wait_seconds,
  output logic [1:0]  link_state,
  output logic [2:0]  status
);
  import rkc_pkg::*;

  logic [3:0] base_wait, wait_cap_factor, sends_per_try, alive_period, lost_limit;
  logic [2:0] try_limit;
  logic [4:0] pause_between;

  logic        in_q_valid;
  logic [1:0]  op_q;
  logic [7:0]  type_q;
  logic [55:0] name_q;
  logic [63:0] mach_q;
  logic [39:0] macl_q;
  logic [55:0] rand_q;

  phase_t      phase, phase_next;
  logic        pausing, pausing_next;
  logic [3:0]  send_index, send_index_next;
  logic [2:0]  try_count, try_count_next;
  logic [3:0]  lost_remaining, lost_remaining_next;
  logic [55:0] srv_name;
  logic [63:0] server_mac_high;
  logic [39:0] server_mac_low;
  logic [55:0] session_random, session_random_next;
  logic        store_id;

  logic [1:0]  kind_c;
  logic [55:0] rnd_c;
  logic [6:0]  wait_c;
  logic [2:0]  status_c;

  logic move;
  assign move     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !move;

  function automatic logic [3:0] at_least_one(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  function automatic logic [6:0] reg_wait(input logic [3:0] j, input logic [3:0] b,
                                          input logic [3:0] c);
    logic [7:0] w;
    if (j < 4'd2) begin
      w = {4'd0, b};
    end else if (j < c) begin
      w = {4'd0, b} * {4'd0, j};
    end else begin
      w = {4'd0, b} * {4'd0, c};
    end
    return (w > 8'd127) ? 7'd127 : w[6:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      base_wait       <= 4'd2;
      wait_cap_factor <= 4'd4;
      sends_per_try   <= 4'd8;
      try_limit       <= 3'd3;
      pause_between   <= 5'd5;
      alive_period    <= 4'd3;
      lost_limit      <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_WAIT:     base_wait       <= cfg_data[3:0];
        CFG_WAIT_CAP:      wait_cap_factor <= cfg_data[3:0];
        CFG_SENDS_PER_TRY: sends_per_try   <= cfg_data[3:0];
        CFG_TRY_LIMIT:     try_limit       <= cfg_data[2:0];
        CFG_PAUSE:         pause_between   <= cfg_data;
        CFG_ALIVE_PERIOD:  alive_period    <= cfg_data[3:0];
        CFG_LOST_LIMIT:    lost_limit      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (move) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q   <= opcode;
      type_q <= pkt_type;
      name_q <= pkt_name;
      mach_q <= pkt_mac_high;
      macl_q <= pkt_mac_low;
      rand_q <= pkt_random;
    end
  end

  always_comb begin
    logic begin_try, end_try, next_req, send_req, send_ka, go_idle, same_id, give_up;
    logic [3:0] try_next;
    begin_try = 1'b0;
    end_try   = 1'b0;
    next_req  = 1'b0;
    send_req  = 1'b0;
    send_ka   = 1'b0;
    go_idle   = 1'b0;
    store_id  = 1'b0;
    same_id   = (name_q == srv_name) && (mach_q == server_mac_high) &&
                (macl_q == server_mac_low) && (rand_q == session_random);
    try_next  = {1'b0, try_count} + 4'd1;
    give_up   = try_next >= at_least_one({1'b0, try_limit});
    phase_next          = phase;
    pausing_next        = pausing;
    send_index_next     = send_index;
    try_count_next      = try_count;
    lost_remaining_next = lost_remaining;
    session_random_next = session_random;
    kind_c   = SEND_NONE;
    rnd_c    = 56'd0;
    wait_c   = 7'd0;
    status_c = ST_NONE;

    case (opcode_t'(op_q))
      OP_START: begin
        if (phase == PH_DISC && !pausing) begin
          session_random_next = RANDOM_RESET;
          try_count_next      = 3'd0;
          lost_remaining_next = 4'd0;
          begin_try           = 1'b1;
        end
      end
      OP_QUIT: begin
        go_idle  = 1'b1;
        status_c = ST_STOPPED;
      end
      OP_EXPIRE: begin
        if (pausing) begin
          begin_try = 1'b1;
        end else if (phase == PH_WAIT) begin
          next_req = 1'b1;
        end else if (phase == PH_REGD || phase == PH_ALIVE) begin
          if (lost_remaining == 4'd0) begin
            go_idle  = 1'b1;
            status_c = ST_ALIVE_LOST;
          end else begin
            lost_remaining_next = lost_remaining - 4'd1;
            send_ka             = 1'b1;
          end
        end
      end
      OP_PACKET: begin
        if (phase == PH_WAIT && !pausing) begin
          if (type_q == TYPE_REG_ACK) begin
            store_id            = 1'b1;
            session_random_next = rand_q;
            phase_next          = PH_REGD;
            pausing_next        = 1'b0;
            send_index_next     = 4'd0;
            try_count_next      = 3'd0;
            lost_remaining_next = at_least_one(lost_limit) - 4'd1;
            status_c            = ST_REGISTERED;
            send_ka             = 1'b1;
          end else if (type_q == TYPE_REG_NACK) begin
            phase_next = PH_DISC;
            end_try    = 1'b1;
          end else if (type_q == TYPE_REG_REJ) begin
            go_idle  = 1'b1;
            status_c = ST_REJECTED;
          end else begin
            next_req = 1'b1;
          end
        end else if (phase == PH_REGD || phase == PH_ALIVE) begin
          if (same_id && type_q == TYPE_ALIVE_ACK) begin
            lost_remaining_next = at_least_one(lost_limit);
            phase_next          = PH_ALIVE;
          end else if (same_id && type_q == TYPE_ALIVE_REJ) begin
            session_random_next = RANDOM_RESET;
            try_count_next      = 3'd0;
            lost_remaining_next = 4'd0;
            begin_try           = 1'b1;
            status_c            = ST_ALIVE_REJ;
          end
        end
      end
      default: ;
    endcase

    if (next_req) begin
      if ({1'b0, send_index} + 5'd1 >= {1'b0, at_least_one(sends_per_try)}) begin
        end_try = 1'b1;
      end else begin
        send_index_next = send_index + 4'd1;
        send_req        = 1'b1;
      end
    end
    if (end_try) begin
      if (give_up) begin
        go_idle  = 1'b1;
        status_c = ST_GAVE_UP;
      end else begin
        try_count_next  = try_next[2:0];
        send_index_next = 4'd0;
        if (pause_between == 5'd0) begin
          begin_try = 1'b1;
        end else begin
          pausing_next = 1'b1;
          wait_c       = {2'd0, pause_between};
        end
      end
    end
    if (begin_try) begin
      send_index_next = 4'd0;
      pausing_next    = 1'b0;
      phase_next      = PH_WAIT;
      send_req        = 1'b1;
    end
    if (send_req) begin
      kind_c = SEND_REQ;
      rnd_c  = session_random_next;
      wait_c = reg_wait(send_index_next, at_least_one(base_wait),
                        at_least_one(wait_cap_factor));
    end
    if (send_ka) begin
      kind_c = SEND_ALIVE;
      rnd_c  = session_random_next;
      wait_c = {3'd0, at_least_one(alive_period)};
    end
    if (go_idle) begin
      phase_next          = PH_DISC;
      pausing_next        = 1'b0;
      send_index_next     = 4'd0;
      try_count_next      = 3'd0;
      lost_remaining_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DISC;
      pausing         <= 1'b0;
      send_index      <= 4'd0;
      try_count       <= 3'd0;
      lost_remaining  <= 4'd0;
      srv_name        <= 56'd0;
      server_mac_high <= 64'd0;
      server_mac_low  <= 40'd0;
      session_random  <= RANDOM_RESET;
    end else if (move) begin
      phase          <= phase_next;
      pausing        <= pausing_next;
      send_index     <= send_index_next;
      try_count      <= try_count_next;
      lost_remaining <= lost_remaining_next;
      session_random <= session_random_next;
      if (store_id) begin
        srv_name        <= name_q;
        server_mac_high <= mach_q;
        server_mac_low  <= macl_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      send_kind      <= kind_c;
      random_to_send <= rnd_c;
      wait_seconds   <= wait_c;
      link_state     <= phase_next;
      status         <= status_c;
    end
  end

endmodule

// ===== design/rkc_checker.sv =====
// Port checker for the register/keepalive client, bound to the top level.
// Depends on rkc_pkg and register_keepalive_client_top.
module rkc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  send_kind,
  input logic [55:0] random_to_send,
  input logic [6:0]  wait_seconds,
  input logic [1:0]  link_state,
  input logic [2:0]  status
);
  import rkc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(send_kind) && $stable(status) &&
      $stable(random_to_send) && $stable(wait_seconds) && $stable(link_state))
    else $error("Stalled result item changed.");

  a_quiet_random: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_kind == SEND_NONE |-> random_to_send == 56'd0)
    else $error("Random bytes present without a packet to send.");

  a_request_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_kind == SEND_REQ |-> link_state == PH_WAIT && wait_seconds != 7'd0)
    else $error("Register request outside the waiting phase or without a wait.");

  a_alive_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_kind == SEND_ALIVE |->
      (link_state == PH_REGD || link_state == PH_ALIVE) && wait_seconds != 7'd0)
    else $error("Alive packet sent outside the linked phases.");

  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_STOPPED |->
      link_state == PH_DISC && send_kind == SEND_NONE && wait_seconds == 7'd0)
    else $error("Quit did not leave the client idle.");

endmodule

bind register_keepalive_client_top rkc_checker u_rkc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .send_kind      (send_kind),
  .random_to_send (random_to_send),
  .wait_seconds   (wait_seconds),
  .link_state     (link_state),
  .status         (status)
);
